// ----- rtl/core/scm_pkg.sv -----
// types and constants for the serial controller mouse port
// used by the channel execute stage, the top level and the testbench
// no dependencies
package scm_pkg;

  // request kinds on the input channel
  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_READ  = 2'd1,
    REQ_TICK  = 2'd2,
    REQ_ACK   = 2'd3
  } req_type_t;

  // one input item
  typedef struct packed {
    req_type_t         req_type;
    logic [2:0]        addr;
    logic [7:0]        wdata;
    logic signed [7:0] mouse_dx;
    logic signed [7:0] mouse_dy;
    logic [7:0]        mouse_buttons;
  } in_item_t;

  // one result item
  typedef struct packed {
    logic [7:0] rdata;
    logic       irq_line;
    logic [7:0] vector;
    logic       vector_valid;
  } out_item_t;

  // item held in the execute stage, with the register selection made at accept
  typedef struct packed {
    in_item_t   item;
    logic       ch;
    logic [3:0] sel;
  } exec_op_t;

  // bus addresses
  localparam logic [2:0] ADDR_CMD_B  = 3'd1;
  localparam logic [2:0] ADDR_DATA_B = 3'd3;
  localparam logic [2:0] ADDR_CMD_A  = 3'd5;
  localparam logic [2:0] ADDR_DATA_A = 3'd7;

  // channel numbers
  localparam logic CH_A = 1'b0;
  localparam logic CH_B = 1'b1;

  // write register numbers
  localparam logic [3:0] REG_CMD      = 4'd0;
  localparam logic [3:0] REG_INT_MODE = 4'd1;
  localparam logic [3:0] REG_VEC      = 4'd2;
  localparam logic [3:0] REG_RX_CTL   = 4'd3;
  localparam logic [3:0] REG_TX_CTL   = 4'd5;
  localparam logic [3:0] REG_MIC      = 4'd9;

  // command codes in bits 5:3 of the command register
  localparam logic [2:0] CMD_POINT_HIGH = 3'd1;
  localparam logic [2:0] CMD_RESET_IUS  = 3'd7;

  // receive interrupt modes in bits 4:3 of the interrupt mode register
  localparam logic [1:0] MODE_FIRST_CHAR = 2'd1;
  localparam logic [1:0] MODE_ALL_CHAR   = 2'd2;

  // bit positions
  localparam int RX_ENABLE_BIT = 0;  // receive control register
  localparam int RX_FLAG_BIT   = 2;  // channel A receive control, flag of channel B
  localparam int RTS_BIT       = 1;  // transmit control register
  localparam int MIC_VIS_BIT   = 0;  // status affects vector
  localparam int MIC_NV_BIT    = 1;  // no vector
  localparam int MIC_MIE_BIT   = 3;  // master interrupt enable
  localparam int MIC_HIGH_BIT  = 4;  // status high

  // status values
  localparam logic [7:0] RR0_RX_AVAIL = 8'h01;
  localparam logic [7:0] RR0_TX_EMPTY = 8'h04;
  localparam logic [7:0] RD_UNMAPPED  = 8'hFF;
  localparam logic [2:0] VEC_STATUS   = 3'b010;
  localparam logic [1:0] RX_FULL      = 2'd3;

endpackage

// ----- rtl/core/scm_regmem.sv -----
// write register memory, 32 entries of 8 bits, channel A at 0..15, channel B at 16..31
// read-first: a read and a write of one entry in one cycle return the old byte
// depends on nothing
module scm_regmem (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  logic       we,
  input  logic [4:0] addr,
  input  logic [7:0] wdata,
  output logic [7:0] rdata
);

  logic [7:0]  mem [32];
  logic [31:0] vld_r;
  logic [7:0]  rdata_r;

  // entries not written since reset read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en && we) begin
      vld_r[addr] <= 1'b1;
    end
  end

  // registered read of the old byte, then the write
  always_ff @(posedge clk) begin
    if (en) begin
      rdata_r <= vld_r[addr] ? mem[addr] : 8'h00;
      if (we) begin
        mem[addr] <= wdata;
      end
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/scm_exec.sv -----
// execute stage: receive buffer, counts, interrupt state and shadow register bits
// uses scm_pkg; gets the old register byte from scm_regmem
module scm_exec (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              go,
  input  scm_pkg::exec_op_t op,
  input  logic [7:0]        prev,
  output scm_pkg::out_item_t result
);

  import scm_pkg::*;

  logic [1:0] rx_cnt_r   [2];
  logic [1:0] rx_cnt_nxt [2];
  logic       rx_en_r    [2];
  logic       rx_en_nxt  [2];
  logic       flag_r, flag_nxt;
  logic       in_svc_r, in_svc_nxt;
  logic       irq_r, irq_nxt;
  logic [7:0] vec_base_r, vec_base_nxt;
  logic [7:0] mic_r, mic_nxt;
  logic [1:0] mode_r, mode_nxt;
  // channel B sample: dy, dx, buttons; channel A is never read back
  logic [7:0] rxb_r   [3];
  logic [7:0] rxb_nxt [3];

  logic       is_cmd;
  logic       load;
  logic [1:0] pop_idx;
  logic [7:0] vec;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_cnt_r[0] <= '0;
      rx_cnt_r[1] <= '0;
      rx_en_r[0]  <= 1'b0;
      rx_en_r[1]  <= 1'b0;
      flag_r      <= 1'b0;
      in_svc_r    <= 1'b0;
      irq_r       <= 1'b0;
      vec_base_r  <= '0;
      mic_r       <= '0;
      mode_r      <= '0;
    end else if (go) begin
      rx_cnt_r   <= rx_cnt_nxt;
      rx_en_r    <= rx_en_nxt;
      flag_r     <= flag_nxt;
      in_svc_r   <= in_svc_nxt;
      irq_r      <= irq_nxt;
      vec_base_r <= vec_base_nxt;
      mic_r      <= mic_nxt;
      mode_r     <= mode_nxt;
    end
  end

  // sample bytes
  always_ff @(posedge clk) begin
    if (go) begin
      rxb_r <= rxb_nxt;
    end
  end

  // decode helpers
  always_comb begin
    is_cmd  = (op.item.addr == ADDR_CMD_A) || (op.item.addr == ADDR_CMD_B);
    load    = op.item.wdata[RTS_BIT] && !prev[RTS_BIT] && rx_en_r[op.ch] &&
              (rx_cnt_r[op.ch] == 2'd0);
    pop_idx = rx_cnt_r[CH_B] - 2'd1;
    vec     = vec_base_r;
    if (mic_r[MIC_VIS_BIT]) begin
      if (mic_r[MIC_HIGH_BIT]) begin
        vec[6:4] = VEC_STATUS;
      end else begin
        vec[3:1] = VEC_STATUS;
      end
    end
  end

  // next state and result
  always_comb begin
    rx_cnt_nxt   = rx_cnt_r;
    rx_en_nxt    = rx_en_r;
    flag_nxt     = flag_r;
    in_svc_nxt   = in_svc_r;
    irq_nxt      = irq_r;
    vec_base_nxt = vec_base_r;
    mic_nxt      = mic_r;
    mode_nxt     = mode_r;
    rxb_nxt      = rxb_r;
    result       = '0;
    case (op.item.req_type)
      REQ_WRITE: begin
        if (is_cmd) begin
          case (op.sel)
            REG_CMD: begin
              if (op.item.wdata[5:3] == CMD_RESET_IUS) begin
                in_svc_nxt = 1'b0;
                flag_nxt   = 1'b0;
              end
            end
            REG_INT_MODE: begin
              if (op.ch == CH_B) begin
                mode_nxt = op.item.wdata[4:3];
              end
            end
            REG_VEC: begin
              vec_base_nxt = op.item.wdata;
            end
            REG_RX_CTL: begin
              rx_en_nxt[op.ch] = op.item.wdata[RX_ENABLE_BIT];
              if (op.ch == CH_A) begin
                flag_nxt = op.item.wdata[RX_FLAG_BIT];
              end
            end
            REG_TX_CTL: begin
              if (load) begin
                rx_cnt_nxt[op.ch] = RX_FULL;
                if (op.ch == CH_B) begin
                  rxb_nxt[0] = op.item.mouse_dy;
                  rxb_nxt[1] = op.item.mouse_dx;
                  rxb_nxt[2] = op.item.mouse_buttons;
                end
              end
            end
            REG_MIC: begin
              if (op.ch == CH_B) begin
                mic_nxt = op.item.wdata;
              end
            end
            default: begin
            end
          endcase
        end
      end
      REQ_READ: begin
        case (op.item.addr)
          ADDR_CMD_A, ADDR_CMD_B: begin
            if (op.sel == REG_CMD) begin
              result.rdata = RR0_TX_EMPTY |
                             ((rx_cnt_r[op.ch] != 2'd0) ? RR0_RX_AVAIL : 8'h00);
            end
          end
          ADDR_DATA_B: begin
            if (rx_cnt_r[CH_B] != 2'd0) begin
              rx_cnt_nxt[CH_B] = pop_idx;
              result.rdata     = rxb_r[pop_idx];
            end
          end
          ADDR_DATA_A: begin
            result.rdata = 8'h00;
          end
          default: begin
            result.rdata = RD_UNMAPPED;
          end
        endcase
      end
      REQ_TICK: begin
        if (!in_svc_r && (rx_cnt_r[CH_B] != 2'd0) && mic_r[MIC_MIE_BIT] &&
            (((mode_r == MODE_FIRST_CHAR) && (rx_cnt_r[CH_B] == RX_FULL)) ||
             (mode_r == MODE_ALL_CHAR))) begin
          in_svc_nxt = 1'b1;
          flag_nxt   = 1'b1;
          irq_nxt    = 1'b1;
        end
      end
      REQ_ACK: begin
        if (flag_r && !mic_r[MIC_NV_BIT]) begin
          result.vector       = vec;
          result.vector_valid = 1'b1;
        end
        irq_nxt = 1'b0;
      end
      default: begin
      end
    endcase
    result.irq_line = irq_nxt;
  end

endmodule

// ----- rtl/core/serial_controller_mouse_port.sv -----
// top level of the serial controller mouse port
// uses scm_pkg, scm_regmem and scm_exec
//
// Usage:
//   in_valid/in_stall/in_data carry one bus write, bus read, timer tick or
//   interrupt acknowledge per transfer; out_valid/out_stall/out_data carry
//   exactly one result per item, in order.
//   A result passes the execute stage register and the output register
//   before it shows on out_valid, and is taken at an edge where out_stall is low.
//   Throughput: one item per cycle while in_stall is low; the register memory
//   has one port and is read and written once at each input transfer; the
//   register pointer is updated at that transfer, and the old byte is registered.
//   Pipeline: accept stage (pointer, memory access), execute stage (buffer,
//   counts, interrupt state), output register.
//   Reset: rst_n low clears pointers, counts, interrupt state, the shadow
//   register bits and the memory's written flags, so unwritten register
//   entries read as zero; the pipeline empties. No clearing pass is needed.
//   Stall: while out_stall holds a result, one more item is still taken into
//   the execute stage; after that in_stall goes high until the output drains.
module serial_controller_mouse_port (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  scm_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output scm_pkg::out_item_t out_data
);

  import scm_pkg::*;

  logic [3:0] ptr_r   [2];
  logic [3:0] ptr_nxt [2];
  logic       s1_v_r, s1_v_nxt;
  exec_op_t   s1_r;
  logic       out_v_r, out_v_nxt;
  out_item_t  out_r;

  logic       accept;
  logic       s1_go;
  logic       out_free;
  logic       in_cmd;
  logic       in_ch;
  logic [3:0] in_sel;
  logic [7:0] prev;
  out_item_t  result;

  // handshake
  assign out_free = !out_v_r || !out_stall;
  assign s1_go    = s1_v_r && out_free;
  assign in_stall = s1_v_r && !out_free;
  assign accept   = in_valid && !in_stall;

  // command port decode and register pointer
  always_comb begin
    in_cmd  = ((in_data.addr == ADDR_CMD_A) || (in_data.addr == ADDR_CMD_B)) &&
              ((in_data.req_type == REQ_WRITE) || (in_data.req_type == REQ_READ));
    in_ch   = (in_data.addr == ADDR_CMD_B) ? CH_B : CH_A;
    in_sel  = ptr_r[in_ch];
    ptr_nxt = ptr_r;
    if (accept && in_cmd) begin
      ptr_nxt[in_ch] = REG_CMD;
      if ((in_data.req_type == REQ_WRITE) && (in_sel == REG_CMD)) begin
        ptr_nxt[in_ch] = {in_data.wdata[5:3] == CMD_POINT_HIGH, in_data.wdata[2:0]};
      end
    end
  end

  // pipeline occupancy
  always_comb begin
    s1_v_nxt  = accept ? 1'b1 : (s1_go ? 1'b0 : s1_v_r);
    out_v_nxt = s1_go ? 1'b1 : (out_v_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r[0] <= REG_CMD;
      ptr_r[1] <= REG_CMD;
      s1_v_r   <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      ptr_r   <= ptr_nxt;
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // execute stage operand and output register
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r.item <= in_data;
      s1_r.ch   <= in_ch;
      s1_r.sel  <= in_sel;
    end
    if (s1_go) begin
      out_r <= result;
    end
  end

  // write register memory, old byte feeds the rising RTS test
  scm_regmem u_regmem (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (accept),
    .we    (in_cmd && (in_data.req_type == REQ_WRITE)),
    .addr  ({in_ch, in_sel}),
    .wdata (in_data.wdata),
    .rdata (prev)
  );

  scm_exec u_exec (
    .clk    (clk),
    .rst_n  (rst_n),
    .go     (s1_go),
    .op     (s1_r),
    .prev   (prev),
    .result (result)
  );

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  // an acknowledge always leaves the request line low
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.vector_valid |-> !out_data.irq_line)
    else $error("irq still high after vector issue");

  // no vector value without a vector
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.vector_valid |-> out_data.vector == 8'h00)
    else $error("vector without vector_valid");

  // a full pipeline with a held result takes nothing more
  assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && out_v_r && out_stall |-> in_stall)
    else $error("transfer taken into a full pipeline");

  // only bus reads return data
  assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && (s1_r.item.req_type != REQ_READ) |=> out_data.rdata == 8'h00)
    else $error("read data on a non-read item");

endmodule

// ----- tb/tb_top.sv -----
// testbench for the serial controller mouse port: directed and random bus traffic
// checks every reply against a predictor of the register file, buffers and interrupt state
// depends on scm_pkg and serial_controller_mouse_port
module tb_top;
  import scm_pkg::*;

  localparam int DIRECTED_ITEMS = 26;
  localparam int RANDOM_ITEMS   = 1800;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int DRAIN_LIMIT    = 2000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int REPORT_LIMIT   = 10;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_SPARSE,
    STALL_RUNS,
    STALL_HEAVY
  } stall_mode_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  // stimulus waiting to be driven and replies waiting to be seen
  in_item_t  bus_items[$];
  out_item_t reply_q[$];

  // predictor state
  logic [7:0] wreg[32];
  logic [3:0] wptr[2];
  logic [7:0] rxbuf[6];
  logic [1:0] rxcnt[2];
  logic       ius;
  logic       irq_lvl;

  int fail_count = 0;
  int cycle_count = 0;
  int burst_left = 1;
  int gap_left = 0;
  int stall_phase_left = 0;
  int stall_run_left = 0;
  stall_mode_t stall_mode = STALL_NONE;

  serial_controller_mouse_port DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #2 clk = ~clk;

  function automatic logic [2:0] cmd_addr(input logic ch);
    return (ch == CH_B) ? ADDR_CMD_B : ADDR_CMD_A;
  endfunction

  function automatic logic [2:0] data_addr(input logic ch);
    return (ch == CH_B) ? ADDR_DATA_B : ADDR_DATA_A;
  endfunction

  // command port write through the register pointer
  function automatic void cmd_write(input logic ch, input logic [7:0] d, input in_item_t it);
    int         base;
    int         chi;
    logic [3:0] sel;
    logic [7:0] prev;
    chi  = (ch == CH_B) ? 1 : 0;
    base = chi * 16;
    sel  = wptr[chi];
    prev = wreg[base + sel];
    wreg[base + sel] = d;
    wptr[chi] = 4'd0;
    if (sel == REG_CMD) begin
      wptr[chi] = {1'b0, d[2:0]};
      if (d[5:3] == CMD_POINT_HIGH) begin
        wptr[chi] = wptr[chi] + 4'd8;
      end else if (d[5:3] == CMD_RESET_IUS) begin
        ius = 1'b0;
        wreg[REG_RX_CTL][RX_FLAG_BIT] = 1'b0;
      end
    end else if (sel == REG_VEC) begin
      wreg[REG_VEC] = d;
    end else if (sel == REG_TX_CTL) begin
      // rising rts with receive enabled samples the mouse into an empty buffer
      if (!prev[RTS_BIT] && d[RTS_BIT] && wreg[base + REG_RX_CTL][RX_ENABLE_BIT] &&
          rxcnt[chi] == 2'd0) begin
        rxbuf[chi * 3 + 0] = it.mouse_dy;
        rxbuf[chi * 3 + 1] = it.mouse_dx;
        rxbuf[chi * 3 + 2] = it.mouse_buttons;
        rxcnt[chi] = RX_FULL;
      end
    end
  endfunction

  // status read; the pointer always returns to zero
  function automatic logic [7:0] cmd_read(input logic ch);
    int         chi;
    logic [3:0] sel;
    logic [7:0] r;
    chi = (ch == CH_B) ? 1 : 0;
    sel = wptr[chi];
    r = 8'h00;
    wptr[chi] = 4'd0;
    if (sel == REG_CMD) begin
      if (rxcnt[chi] != 2'd0) r = r | RR0_RX_AVAIL;
      r = r | RR0_TX_EMPTY;
    end
    return r;
  endfunction

  // expected reply of one item, updating the predictor state
  function automatic out_item_t predict_reply(input in_item_t it);
    out_item_t  rep;
    logic [7:0] mic;
    logic [7:0] v;
    logic [1:0] mode;
    rep = '0;
    case (it.req_type)
      REQ_WRITE: begin
        if (it.addr == ADDR_CMD_B) cmd_write(CH_B, it.wdata, it);
        else if (it.addr == ADDR_CMD_A) cmd_write(CH_A, it.wdata, it);
      end
      REQ_READ: begin
        case (it.addr)
          ADDR_CMD_B: rep.rdata = cmd_read(CH_B);
          ADDR_CMD_A: rep.rdata = cmd_read(CH_A);
          ADDR_DATA_B: begin
            if (rxcnt[1] != 2'd0) begin
              rxcnt[1] = rxcnt[1] - 2'd1;
              rep.rdata = rxbuf[3 + int'(rxcnt[1])];
            end
          end
          ADDR_DATA_A: rep.rdata = 8'h00;
          default: rep.rdata = RD_UNMAPPED;
        endcase
      end
      REQ_TICK: begin
        if (!ius && rxcnt[1] != 2'd0 && wreg[16 + REG_MIC][MIC_MIE_BIT]) begin
          mode = wreg[16 + REG_INT_MODE][4:3];
          if ((mode == MODE_FIRST_CHAR && rxcnt[1] == RX_FULL) || mode == MODE_ALL_CHAR) begin
            ius = 1'b1;
            wreg[REG_RX_CTL][RX_FLAG_BIT] = 1'b1;
            irq_lvl = 1'b1;
          end
        end
      end
      default: begin
        mic = wreg[16 + REG_MIC];
        if (wreg[REG_RX_CTL][RX_FLAG_BIT] && !mic[MIC_NV_BIT]) begin
          v = wreg[REG_VEC];
          if (mic[MIC_VIS_BIT]) begin
            if (mic[MIC_HIGH_BIT]) v[6:4] = VEC_STATUS;
            else v[3:1] = VEC_STATUS;
          end
          wreg[16 + REG_VEC] = v;
          rep.vector = v;
          rep.vector_valid = 1'b1;
        end
        irq_lvl = 1'b0;
      end
    endcase
    rep.irq_line = irq_lvl;
    return rep;
  endfunction

  task automatic add_item(input req_type_t r, input logic [2:0] a, input logic [7:0] d,
                          input logic [7:0] dx, input logic [7:0] dy, input logic [7:0] btn);
    in_item_t it;
    it.req_type      = r;
    it.addr          = a;
    it.wdata         = d;
    it.mouse_dx      = dx;
    it.mouse_dy      = dy;
    it.mouse_buttons = btn;
    bus_items.push_back(it);
  endtask

  task automatic add_bus(input req_type_t r, input logic [2:0] a, input logic [7:0] d);
    add_item(r, a, d, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // aim the pointer at a register; a no-op for register zero
  task automatic point_to(input logic ch, input logic [3:0] regno);
    logic [2:0] code;
    if (regno != REG_CMD) begin
      if (regno[3]) begin
        code = CMD_POINT_HIGH;
      end else begin
        code = 3'($urandom_range(0, 5));
        if (code != 3'd0) code = code + 3'd1;
      end
      add_bus(REQ_WRITE, cmd_addr(ch), {2'($urandom), code, regno[2:0]});
    end
  endtask

  task automatic set_reg(input logic ch, input logic [3:0] regno, input logic [7:0] val);
    point_to(ch, regno);
    add_bus(REQ_WRITE, cmd_addr(ch), val);
  endtask

  // driver: bursts of transfers with random gaps, payload held while stalled
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (gap_left > 0) begin
        gap_left = gap_left - 1;
        in_valid <= 1'b0;
      end else if (bus_items.size() > 0) begin
        in_valid <= 1'b1;
        in_data <= bus_items.pop_front();
        burst_left = burst_left - 1;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 32);
          gap_left = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall pattern, with its character picked anew for each phase of random length
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_phase_left == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 3));
        stall_phase_left = $urandom_range(50, 300);
      end else begin
        stall_phase_left = stall_phase_left - 1;
      end
      case (stall_mode)
        STALL_NONE:   out_stall <= 1'b0;
        STALL_SPARSE: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_RUNS: begin
          if (stall_run_left > 0) begin
            stall_run_left = stall_run_left - 1;
          end else begin
            out_stall <= ~out_stall;
            stall_run_left = $urandom_range(0, 7);
          end
        end
        default:      out_stall <= ($urandom_range(0, 1) == 1);
      endcase
    end
  end

  // monitor: check each reply transfer, then predict the reply of each item transfer
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      for (int i = 0; i < 32; i++) wreg[i] = 8'h00;
      for (int i = 0; i < 6; i++) rxbuf[i] = 8'h00;
      wptr[0] = 4'd0;
      wptr[1] = 4'd0;
      rxcnt[0] = 2'd0;
      rxcnt[1] = 2'd0;
      ius = 1'b0;
      irq_lvl = 1'b0;
      reply_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (reply_q.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("unexpected reply at cycle %0d: rdata=%h irq=%b vector=%h vvalid=%b",
                     cycle_count, out_data.rdata, out_data.irq_line, out_data.vector,
                     out_data.vector_valid);
        end else begin
          want = reply_q.pop_front();
          if (out_data.rdata !== want.rdata || out_data.irq_line !== want.irq_line ||
              out_data.vector !== want.vector ||
              out_data.vector_valid !== want.vector_valid) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
              $display("reply mismatch at cycle %0d: expected rdata=%h irq=%b vector=%h %s%b",
                       cycle_count, want.rdata, want.irq_line, want.vector, "vvalid=",
                       want.vector_valid);
            if (fail_count <= REPORT_LIMIT)
              $display("  actual rdata=%h irq=%b vector=%h vvalid=%b",
                       out_data.rdata, out_data.irq_line, out_data.vector,
                       out_data.vector_valid);
          end
        end
      end
      if (in_valid && !in_stall) reply_q.push_back(predict_reply(in_data));
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int         pick;
    int         guard;
    logic       ch;
    logic [7:0] v;

    // directed: reset state, unmapped and ignored accesses, then one full mouse interrupt
    add_bus(REQ_READ, ADDR_CMD_B, 8'h00);
    add_bus(REQ_READ, 3'd0, 8'h00);
    add_bus(REQ_READ, 3'd6, 8'h00);
    add_bus(REQ_READ, ADDR_DATA_A, 8'h00);
    add_bus(REQ_READ, ADDR_DATA_B, 8'h00);
    add_bus(REQ_WRITE, ADDR_DATA_B, 8'hFF);
    add_bus(REQ_WRITE, 3'd4, 8'hFF);
    add_bus(REQ_TICK, 3'd0, 8'h00);
    add_bus(REQ_ACK, 3'd0, 8'h00);
    set_reg(CH_B, REG_RX_CTL, 8'hFF);
    set_reg(CH_B, REG_MIC, 8'h09);
    set_reg(CH_B, REG_INT_MODE, 8'h08);
    set_reg(CH_B, REG_VEC, 8'hFF);
    point_to(CH_B, REG_TX_CTL);
    add_item(REQ_WRITE, ADDR_CMD_B, 8'h02, 8'h80, 8'h7F, 8'hFF);
    add_bus(REQ_TICK, 3'd0, 8'h00);
    add_bus(REQ_ACK, 3'd0, 8'h00);
    add_bus(REQ_WRITE, ADDR_CMD_B, {2'b00, CMD_RESET_IUS, 3'b000});
    repeat (3) add_bus(REQ_READ, ADDR_DATA_B, 8'h00);
    add_bus(REQ_READ, ADDR_CMD_A, 8'h00);

    // random: mouse sample sequences (the largest share), plus register traffic and noise
    while (bus_items.size() < DIRECTED_ITEMS + RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      ch = ($urandom_range(0, 4) == 0) ? CH_A : CH_B;
      if (pick < 40) begin
        add_bus(REQ_READ, cmd_addr(ch), 8'($urandom));
        if ($urandom_range(0, 1) == 1) begin
          v = 8'($urandom);
          v[RX_ENABLE_BIT] = ($urandom_range(0, 9) != 0);
          set_reg(ch, REG_RX_CTL, v);
        end
        if ($urandom_range(0, 3) == 0) begin
          v = 8'($urandom);
          if ($urandom_range(0, 3) != 0) begin
            v[MIC_MIE_BIT] = 1'b1;
            v[MIC_NV_BIT] = 1'b0;
          end
          set_reg(ch, REG_MIC, v);
        end
        if ($urandom_range(0, 3) == 0) set_reg(ch, REG_INT_MODE, 8'($urandom));
        if ($urandom_range(0, 3) == 0) set_reg(ch, REG_VEC, 8'($urandom));
        // a second rts pulse, when there is one, finds the buffer still full if the first loaded it
        repeat ($urandom_range(1, 2)) begin
          v = 8'($urandom);
          v[RTS_BIT] = 1'b0;
          set_reg(ch, REG_TX_CTL, v);
          v = 8'($urandom);
          v[RTS_BIT] = 1'b1;
          set_reg(ch, REG_TX_CTL, v);
        end
        repeat ($urandom_range(0, 6)) begin
          case ($urandom_range(0, 3))
            0:       add_bus(REQ_TICK, 3'($urandom), 8'($urandom));
            1:       add_bus(REQ_ACK, 3'($urandom), 8'($urandom));
            2:       add_bus(REQ_READ, cmd_addr(ch), 8'($urandom));
            default: add_bus(REQ_READ, data_addr(ch), 8'($urandom));
          endcase
        end
        repeat ($urandom_range(0, 3)) add_bus(REQ_READ, data_addr(ch), 8'($urandom));
        if ($urandom_range(0, 1) == 1)
          add_bus(REQ_WRITE, cmd_addr(ch), {2'($urandom), CMD_RESET_IUS, 3'b000});
      end else if (pick < 55) begin
        add_bus(REQ_READ, cmd_addr(ch), 8'($urandom));
        set_reg(ch, 4'($urandom_range(1, 15)), 8'($urandom));
      end else if (pick < 65) begin
        add_bus(REQ_READ, cmd_addr(ch), 8'($urandom));
        add_bus(REQ_WRITE, cmd_addr(ch), {2'($urandom), CMD_RESET_IUS, 3'($urandom)});
      end else if (pick < 75) begin
        add_bus(REQ_READ, cmd_addr(ch), 8'($urandom));
        point_to(ch, 4'($urandom_range(0, 15)));
        add_bus(REQ_READ, cmd_addr(ch), 8'($urandom));
      end else if (pick < 85) begin
        add_bus(($urandom_range(0, 1) == 1) ? REQ_TICK : REQ_ACK, 3'($urandom), 8'($urandom));
      end else begin
        add_bus(req_type_t'($urandom_range(0, 3)), 3'($urandom), 8'($urandom));
      end
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // drain: all items sent, all replies seen, then a quiet settling wait
    while (bus_items.size() != 0 || in_valid) @(posedge clk);
    guard = 0;
    while (reply_q.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    fail_count += reply_q.size();

    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/scm_pkg.sv
rtl/core/scm_regmem.sv
rtl/core/scm_exec.sv
rtl/core/serial_controller_mouse_port.sv
tb/tb_top.sv
